// ===== hdl/trb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trb_pkg: shared types and constants for the timestamp reorder buffer
// Holds the event record, field widths and the controller/datapath interface.
// ----------------------------------------------------------------------------
package trb_pkg;

    localparam int unsigned DEPTH   = 64;
    localparam int unsigned IDX_W   = $clog2(DEPTH);
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
    localparam int unsigned LIMIT_W = 7;
    localparam int unsigned TS_W    = 47;
    localparam int unsigned TS_POS  = 31;
    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

    typedef logic [2:0] t_status;
    localparam t_status ST_STORED  = 3'd0;
    localparam t_status ST_EMITTED = 3'd1;
    localparam t_status ST_DISCARD = 3'd2;
    localparam t_status ST_FLUSHED = 3'd3;
    localparam t_status ST_EMPTY   = 3'd4;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [TS_W-1:0] ts;
        logic [15:0]     board;
        logic [15:0]     channel;
        logic [31:0]     energy;
    } t_event;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture the incoming event
        logic insert;    // insert the captured event (one shift step)
        logic pop;       // remove head, shift down
        logic clear;     // empty the store
        logic count_dis; // bump the discard counter
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] occ;
        logic             older; // captured ts below head
    } t_stat;

endpackage
`default_nettype wire

// ===== hdl/trb_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trb_datapath: sorted event store
// A register array kept in ascending timestamp order; insertion and head
// removal are done by a single parallel shift, one compare per entry.
// ----------------------------------------------------------------------------
module trb_datapath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire trb_pkg::t_event i_event,
    input  wire trb_pkg::t_cmd  i_cmd,
    output trb_pkg::t_stat      o_stat,
    output trb_pkg::t_event     o_head,
    output logic [31:0]         o_discards
);
    import trb_pkg::*;

    t_event           r_store [DEPTH];
    t_event           r_new;
    logic [CNT_W-1:0] r_occ;
    logic [31:0]      r_dis;
    logic [DEPTH-1:0] w_ge; // entry holds ts >= new ts (or is empty)

    // compare every valid entry against the captured event
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ge[i] = (CNT_W'(i) >= r_occ) || (r_store[i].ts >= r_new.ts);
        end
    end

    // shift store: insert new event in front of first entry not below it
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new <= i_event;
        end
        if (i_cmd.insert) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (w_ge[i]) begin
                    if (i == 0 || !w_ge[(i == 0) ? 0 : i-1]) begin
                        r_store[i] <= r_new;
                    end else begin
                        r_store[i] <= r_store[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_store[i] <= r_store[i+1];
            end
        end
    end

    // occupancy and discard counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
            r_dis <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_occ <= '0;
            end else if (i_cmd.insert && !i_cmd.pop) begin
                r_occ <= r_occ + CNT_W'(1);
            end else if (i_cmd.pop && !i_cmd.insert) begin
                r_occ <= r_occ - CNT_W'(1);
            end
            if (i_cmd.count_dis && r_dis != CNT_MAX) begin
                r_dis <= r_dis + 32'd1;
            end
        end
    end

    assign o_stat.occ   = r_occ;
    assign o_stat.older = r_new.ts < r_store[0].ts;
    assign o_head       = r_store[0];
    assign o_discards   = r_dis;
endmodule
`default_nettype wire

// ===== hdl/trb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trb_ctrl: sequencer for the reorder buffer
// Decodes each command, steps the store and drives the result strobe.
// ----------------------------------------------------------------------------
module trb_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic                     i_opcode,
    input  wire logic [trb_pkg::LIMIT_W-1:0] i_limit,
    input  wire trb_pkg::t_stat           i_stat,
    input  wire trb_pkg::t_event          i_head,
    output logic                          o_busy,
    output trb_pkg::t_cmd                 o_cmd,
    output logic                          o_valid,
    output trb_pkg::t_status              o_status,
    output trb_pkg::t_event               o_event,
    output logic                          o_last
);
    import trb_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_ADD, S_FIX, S_FLUSH} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] w_lim;
    logic             w_full;
    logic             r_pend; // emitted add still has to insert

    // clamp the limit to 1..DEPTH
    always_comb begin
        if (i_limit == '0) begin
            w_lim = CNT_W'(1);
        end else if (32'(i_limit) > DEPTH) begin
            w_lim = CNT_W'(DEPTH);
        end else begin
            w_lim = CNT_W'(i_limit);
        end
        w_full = i_stat.occ >= w_lim;
    end

    assign o_busy = (r_state != S_IDLE);

    // command decode
    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_start;
        case (r_state)
            S_ADD: begin
                if (!w_full) begin
                    o_cmd.insert = 1'b1;
                end else if (i_stat.older) begin
                    o_cmd.count_dis = 1'b1;
                end else begin
                    o_cmd.pop = 1'b1;
                end
            end
            S_FIX:   o_cmd.insert = r_pend;
            S_FLUSH: begin
                o_cmd.pop   = (i_stat.occ != '0);
                o_cmd.clear = (i_stat.occ <= CNT_W'(1));
            end
            default: ;
        endcase
    end

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= (i_opcode == OP_FLUSH) ? S_FLUSH : S_ADD;
                    end
                end
                S_ADD: begin
                    o_valid  <= 1'b1;
                    o_last   <= 1'b1;
                    o_event  <= '0;
                    r_pend   <= 1'b0;
                    r_state  <= S_IDLE;
                    if (!w_full) begin
                        o_status <= ST_STORED;
                    end else if (i_stat.older) begin
                        o_status <= ST_DISCARD;
                    end else begin
                        o_status <= ST_EMITTED;
                        o_event  <= i_head;
                        r_pend   <= 1'b1;
                        r_state  <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_pend  <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_FLUSH: begin
                    o_valid <= 1'b1;
                    o_last  <= (i_stat.occ <= CNT_W'(1));
                    if (i_stat.occ == '0) begin
                        o_status <= ST_EMPTY;
                        o_event  <= '0;
                    end else begin
                        o_status <= ST_FLUSHED;
                        o_event  <= i_head;
                    end
                    if (i_stat.occ <= CNT_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hdl/timestamp_reorder_buffer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_reorder_buffer_top: event reorder buffer by 47-bit timestamp
//
// Usage: present an item with start high while busy is low; it is taken
// at that edge. i_opcode selects add or flush. Results appear on the o_
// ports for one cycle each, marked by o_valid; o_last_result flags the final
// result of the item. The receiver cannot stall the block.
// Add: the add state decides and the result is then registered; the next
// item can be taken at the edge that ends that result, unless a full store
// emits its head and a fix state must do the insert first. The controller's
// decide/insert sequence over the shift register store sets this order.
// Flush: one result per cycle per held event, oldest first, or one status
// "empty" result.
// o_discard_count reports the saturating discard total after the item.
// Reset (synchronous, active low) empties the store, clears the discard
// count and sets fill_limit to 64. Write fill_limit with i_cfg_we while idle.
// ----------------------------------------------------------------------------
module timestamp_reorder_buffer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_wdata,
    input  wire logic        i_opcode,
    input  wire logic [15:0] i_board_id,
    input  wire logic [15:0] i_channel_id,
    input  wire logic [31:0] i_energy_word,
    input  wire logic [31:0] i_ts_low_word,
    input  wire logic [31:0] i_ts_high_word,
    output logic             o_valid,
    output logic [2:0]       o_status,
    output logic [15:0]      o_out_board,
    output logic [15:0]      o_out_channel,
    output logic [31:0]      o_out_energy,
    output logic [46:0]      o_out_timestamp,
    output logic [31:0]      o_discard_count,
    output logic             o_last_result
);
    import trb_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    t_event  w_in, w_head, w_out;
    t_cmd    w_cmd;
    t_stat   w_stat;
    logic [31:0] w_dis;

    // hold the fill limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // assemble the incoming event
    assign w_in.ts      = {i_ts_high_word[31:16], i_ts_low_word[30:0]};
    assign w_in.board   = i_board_id;
    assign w_in.channel = i_channel_id;
    assign w_in.energy  = i_energy_word;

    trb_datapath u_dp (
        .i_clk, .i_rst_n, .i_event(w_in), .i_cmd(w_cmd),
        .o_stat(w_stat), .o_head(w_head), .o_discards(w_dis)
    );

    trb_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .i_opcode, .i_limit(r_limit),
        .i_stat(w_stat), .i_head(w_head),
        .o_busy(busy), .o_cmd(w_cmd), .o_valid, .o_status,
        .o_event(w_out), .o_last(o_last_result)
    );

    assign o_out_board     = w_out.board;
    assign o_out_channel   = w_out.channel;
    assign o_out_energy    = w_out.energy;
    assign o_out_timestamp = w_out.ts;
    assign o_discard_count = w_dis;
endmodule
`default_nettype wire

// ===== dv/trb_event_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trb_event_checker: result checker for the timestamp reorder buffer
// Watches accepted items and config writes, keeps a sorted copy of the held
// events, predicts every result and compares each strobed result in order.
// ----------------------------------------------------------------------------
module trb_event_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_busy,
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_wdata,
    input  wire logic        i_opcode,
    input  wire logic [15:0] i_board_id,
    input  wire logic [15:0] i_channel_id,
    input  wire logic [31:0] i_energy_word,
    input  wire logic [31:0] i_ts_low_word,
    input  wire logic [31:0] i_ts_high_word,
    input  wire logic        i_valid,
    input  wire logic [2:0]  i_status,
    input  wire logic [15:0] i_out_board,
    input  wire logic [15:0] i_out_channel,
    input  wire logic [31:0] i_out_energy,
    input  wire logic [46:0] i_out_timestamp,
    input  wire logic [31:0] i_discard_count,
    input  wire logic        i_last_result,
    output int               o_fail_count,
    output int               o_pending
);
    import trb_pkg::*;

    typedef struct packed {
        t_status     status;
        t_event      evt;
        logic [31:0] dis;
        logic        last;
    } t_result;

    t_event       sorted_q[$];
    t_result      result_q[$];
    logic [6:0]   limit_reg;
    logic [31:0]  dis_total;

    assign o_pending = result_q.size();

    // queue one predicted result
    task automatic push_result(input t_status st, input t_event ev, input logic lst);
        t_result r;
        r.status = st;
        r.evt    = ev;
        r.dis    = dis_total;
        r.last   = lst;
        result_q.insert(result_q.size(), r);
    endtask

    // insert ahead of equal timestamps
    task automatic insert_sorted(input t_event ev);
        int pos;
        pos = 0;
        while (pos < sorted_q.size() && sorted_q[pos].ts < ev.ts) pos++;
        sorted_q.insert(pos, ev);
    endtask

    // predict results of one accepted item
    task automatic predict_item();
        t_event ev;
        t_event none;
        int     lim;
        int     n;
        none = '0;
        if (i_opcode == OP_FLUSH) begin
            n = sorted_q.size();
            if (n == 0) begin
                push_result(ST_EMPTY, none, 1'b1);
            end else begin
                for (int i = 0; i < n; i++)
                    push_result(ST_FLUSHED, sorted_q[i], i == n - 1);
                sorted_q.delete();
            end
            return;
        end
        ev.ts      = {i_ts_high_word[31:16], i_ts_low_word[30:0]};
        ev.board   = i_board_id;
        ev.channel = i_channel_id;
        ev.energy  = i_energy_word;
        lim = limit_reg;
        if (lim < 1) lim = 1;
        if (lim > DEPTH) lim = DEPTH;
        if (sorted_q.size() < lim) begin
            insert_sorted(ev);
            push_result(ST_STORED, none, 1'b1);
        end else if (ev.ts < sorted_q[0].ts) begin
            if (dis_total != CNT_MAX) dis_total++;
            push_result(ST_DISCARD, none, 1'b1);
        end else begin
            push_result(ST_EMITTED, sorted_q[0], 1'b1);
            void'(sorted_q.pop_front());
            insert_sorted(ev);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        t_result r;
        if (!i_rst_n) begin
            sorted_q.delete();
            result_q.delete();
            limit_reg = LIMIT_RESET;
            dis_total = '0;
        end else begin
            if (i_valid) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result, status %0d", i_status);
                    o_fail_count++;
                end else begin
                    r = result_q.pop_front();
                    check_field("status", 64'(r.status), 64'(i_status));
                    check_field("out_board", 64'(r.evt.board), 64'(i_out_board));
                    check_field("out_channel", 64'(r.evt.channel), 64'(i_out_channel));
                    check_field("out_energy", 64'(r.evt.energy), 64'(i_out_energy));
                    check_field("out_timestamp", 64'(r.evt.ts), 64'(i_out_timestamp));
                    check_field("discard_count", 64'(r.dis), 64'(i_discard_count));
                    check_field("last_result", 64'(r.last), 64'(i_last_result));
                end
            end
            if (i_cfg_we) limit_reg = i_cfg_wdata;
            if (i_start && !i_busy) predict_item();
        end
    end

    initial o_fail_count = 0;

endmodule

// ===== dv/tb_timestamp_reorder_buffer_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timestamp_reorder_buffer_top: stimulus and verdict for the reorder buffer
// Drives directed and random adds and flushes across several fill limits,
// with random start gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_timestamp_reorder_buffer_top;
    import trb_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_we;
    logic [6:0]  cfg_wdata;
    logic        opcode;
    logic [15:0] board_id;
    logic [15:0] channel_id;
    logic [31:0] energy_word;
    logic [31:0] ts_low_word;
    logic [31:0] ts_high_word;
    logic        res_valid;
    logic [2:0]  res_status;
    logic [15:0] res_board;
    logic [15:0] res_channel;
    logic [31:0] res_energy;
    logic [46:0] res_timestamp;
    logic [31:0] res_discard;
    logic        res_last;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          allow_gaps;
    logic [31:0] ts_base;

    timestamp_reorder_buffer_top u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_opcode       (opcode),
        .i_board_id     (board_id),
        .i_channel_id   (channel_id),
        .i_energy_word  (energy_word),
        .i_ts_low_word  (ts_low_word),
        .i_ts_high_word (ts_high_word),
        .o_valid        (res_valid),
        .o_status       (res_status),
        .o_out_board    (res_board),
        .o_out_channel  (res_channel),
        .o_out_energy   (res_energy),
        .o_out_timestamp(res_timestamp),
        .o_discard_count(res_discard),
        .o_last_result  (res_last)
    );

    trb_event_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_opcode       (opcode),
        .i_board_id     (board_id),
        .i_channel_id   (channel_id),
        .i_energy_word  (energy_word),
        .i_ts_low_word  (ts_low_word),
        .i_ts_high_word (ts_high_word),
        .i_valid        (res_valid),
        .i_status       (res_status),
        .i_out_board    (res_board),
        .i_out_channel  (res_channel),
        .i_out_energy   (res_energy),
        .i_out_timestamp(res_timestamp),
        .i_discard_count(res_discard),
        .i_last_result  (res_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: count cycles with no accepted item, result or config write
    always @(posedge clk) begin
        if ((start && !busy) || res_valid || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // present one item and hold it until taken
    task automatic send_item(input logic op, input logic [15:0] b, input logic [15:0] c,
                             input logic [31:0] e, input logic [31:0] lo,
                             input logic [31:0] hi);
        if (allow_gaps && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(negedge clk);
        opcode       = op;
        board_id     = b;
        channel_id   = c;
        energy_word  = e;
        ts_low_word  = lo;
        ts_high_word = hi;
        start        = 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic add_event(input logic [31:0] lo, input logic [31:0] hi);
        send_item(OP_ADD, 16'($urandom), 16'($urandom), $urandom, lo, hi);
    endtask

    // wait out all results, then let the block return to idle
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [6:0] value);
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // random mix: mostly near-ordered timestamps, some flushes and wild values
    task automatic random_phase(input int count);
        logic [31:0] lo;
        logic [31:0] hi;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(OP_FLUSH, 16'($urandom), 16'($urandom), $urandom, $urandom,
                          $urandom);
            end else if ($urandom_range(0, 9) == 0) begin
                add_event($urandom, $urandom);
            end else begin
                ts_base = ts_base + $urandom_range(0, 40);
                lo = {1'($urandom_range(0, 1)),
                      31'(ts_base[30:0] - 31'($urandom_range(0, 60)))};
                hi = {16'h0000, 16'($urandom_range(0, 65535))};
                if ($urandom_range(0, 7) == 0) lo[30:0] = lo[30:0] & 31'h7;
                add_event(lo, hi);
            end
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        opcode       = OP_ADD;
        board_id     = '0;
        channel_id   = '0;
        energy_word  = '0;
        ts_low_word  = '0;
        ts_high_word = '0;
        allow_gaps   = 1'b0;
        ts_base      = 32'd1000;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty flush, equal stamps, extremes, full-store paths
        send_item(OP_FLUSH, '0, '0, '0, '0, '0);
        drain();
        write_limit(7'd3);
        send_item(OP_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_ADD, 16'h0000, 16'h0000, 32'h0, 32'h0000_0005, 32'h0000_FFFF);
        send_item(OP_ADD, 16'h1234, 16'h4321, 32'hA5A5_A5A5, 32'h8000_0005, 32'h0000_0000);
        add_event(32'h0000_0001, 32'h0);
        add_event(32'h0000_0005, 32'h0001_0000);
        add_event(32'h7FFF_FFFF, 32'hFFFF_0000);
        send_item(OP_FLUSH, '0, '0, '0, '0, '0);
        drain();
        write_limit(7'd0);
        add_event(32'd50, 32'h0);
        add_event(32'd40, 32'h0);
        add_event(32'd60, 32'h0);
        add_event(32'd60, 32'h0);
        drain();
        write_limit(7'd127);
        add_event(32'd10, 32'h0);
        drain();
        write_limit(7'd1);
        add_event(32'd70, 32'h0);
        send_item(OP_FLUSH, '0, '0, '0, '0, '0);
        send_item(OP_FLUSH, '0, '0, '0, '0, '0);
        drain();

        // random phases across limits
        allow_gaps = 1'b1;
        write_limit(7'd4);
        random_phase(70);
        drain();
        write_limit(7'd64);
        random_phase(90);
        send_item(OP_FLUSH, '0, '0, '0, '0, '0);
        drain();
        write_limit(7'd2);
        random_phase(50);
        drain();
        write_limit(7'd16);
        random_phase(40);
        drain();
        write_limit(7'd8);
        allow_gaps = 1'b0;
        random_phase(40);
        send_item(OP_FLUSH, '0, '0, '0, '0, '0);
        drain();
        repeat (10) @(negedge clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
